[rtl/tlqe_pkg.sv]
// Types, constants and helpers shared by the thick line quad expander.
`timescale 1ns / 1ps
package tlqe_pkg;

   localparam logic [63:0] ZeroLenScale = 64'd100000000000000;
   localparam logic [2:0]  LastCorner   = 3'd5;
   localparam int          SqrtSteps    = 32;
   localparam int          DivSteps     = 33;

   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] ex;
      logic [31:0] ey;
      logic [31:0] hw;
      logic [31:0] col;
      logic        dx_neg;
      logic        dy_pos;
      logic        drop;
   } side_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [31:0] root;
      logic [63:0] s;
      logic [62:0] na;
      logic [62:0] nb;
   } sq_type;

   typedef struct packed {
      logic [31:0] len;
      logic [31:0] rem_x;
      logic [31:0] rem_y;
      logic [32:0] n_x;
      logic [32:0] n_y;
      logic [32:0] q_x;
      logic [32:0] q_y;
   } dv_type;

   function automatic logic [1:0] corner_sel(input logic [2:0] corner);
      logic [1:0] sel;
      unique case (corner)
         3'd0:    sel = 2'd0;
         3'd1:    sel = 2'd2;
         3'd2:    sel = 2'd1;
         3'd3:    sel = 2'd1;
         3'd4:    sel = 2'd2;
         default: sel = 2'd3;
      endcase
      return sel;
   endfunction

   function automatic logic [31:0] sat32(input logic [35:0] v);
      logic [31:0] r;
      if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) r = v[31:0];
      else if (v[35]) r = 32'h8000_0000;
      else r = 32'h7fff_ffff;
      return r;
   endfunction

endpackage

[rtl/tlqe_sqrt_cell.sv]
// One bit-pair step of the integer square root chain.
`timescale 1ns / 1ps
module tlqe_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  tlqe_pkg::side_type in_side,
   input  tlqe_pkg::sq_type   in_sq,
   output logic              out_valid,
   output tlqe_pkg::side_type out_side,
   output tlqe_pkg::sq_type   out_sq
);
   import tlqe_pkg::*;

   logic     valid_ff;
   side_type side_ff;
   sq_type   sq_ff;
   sq_type   sq_in;
   logic [34:0] t;
   logic [34:0] trial;
   logic        ge;

   always_comb begin
      t     = {in_sq.rem, in_sq.s[63:62]};
      trial = {1'b0, in_sq.root, 2'b01};
      ge    = (t >= trial);
      sq_in      = in_sq;
      sq_in.rem  = ge ? 33'(t - trial) : t[32:0];
      sq_in.root = {in_sq.root[30:0], ge};
      sq_in.s    = {in_sq.s[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         side_ff <= in_side;
         sq_ff   <= sq_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_sq    = sq_ff;
endmodule

[rtl/tlqe_div_cell.sv]
// One quotient bit of the two restoring divider lanes.
`timescale 1ns / 1ps
module tlqe_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  tlqe_pkg::side_type in_side,
   input  tlqe_pkg::dv_type   in_dv,
   output logic              out_valid,
   output tlqe_pkg::side_type out_side,
   output tlqe_pkg::dv_type   out_dv
);
   import tlqe_pkg::*;

   logic     valid_ff;
   side_type side_ff;
   dv_type   dv_ff;
   dv_type   dv_in;
   logic [32:0] tx;
   logic [32:0] ty;
   logic        gx;
   logic        gy;

   always_comb begin
      tx = {in_dv.rem_x, in_dv.n_x[32]};
      ty = {in_dv.rem_y, in_dv.n_y[32]};
      gx = (tx >= {1'b0, in_dv.len});
      gy = (ty >= {1'b0, in_dv.len});
      dv_in       = in_dv;
      dv_in.rem_x = gx ? 32'(tx - {1'b0, in_dv.len}) : tx[31:0];
      dv_in.rem_y = gy ? 32'(ty - {1'b0, in_dv.len}) : ty[31:0];
      dv_in.n_x   = {in_dv.n_x[31:0], 1'b0};
      dv_in.n_y   = {in_dv.n_y[31:0], 1'b0};
      dv_in.q_x   = {in_dv.q_x[31:0], gx};
      dv_in.q_y   = {in_dv.q_y[31:0], gy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         side_ff <= in_side;
         dv_ff   <= dv_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_dv    = dv_ff;
endmodule

[rtl/tlqe_emit.sv]
// Corner builder and six-vertex output sequencer.
`timescale 1ns / 1ps
module tlqe_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tlqe_pkg::side_type in_side,
   input  logic [32:0]       in_qx,
   input  logic [32:0]       in_qy,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_vert_x,
   output logic [31:0]       rsp_vert_y,
   output logic [31:0]       rsp_vert_rgba,
   output logic [2:0]        rsp_corner,
   output logic              rsp_last
);
   import tlqe_pkg::*;

   logic        busy_ff;
   logic [2:0]  cnt_ff;
   logic [31:0] vx_ff [0:3];
   logic [31:0] vy_ff [0:3];
   logic [31:0] col_ff;
   logic [31:0] vx_in [0:3];
   logic [31:0] vy_in [0:3];
   logic [34:0] px;
   logic [34:0] py;
   logic [35:0] sx;
   logic [35:0] sy;
   logic [35:0] ex;
   logic [35:0] ey;
   logic        load;

   always_comb begin
      px = in_side.dy_pos ? 35'(-{2'b00, in_qy}) : {2'b00, in_qy};
      py = in_side.dx_neg ? 35'(-{2'b00, in_qx}) : {2'b00, in_qx};
      sx = {{4{in_side.sx[31]}}, in_side.sx};
      sy = {{4{in_side.sy[31]}}, in_side.sy};
      ex = {{4{in_side.ex[31]}}, in_side.ex};
      ey = {{4{in_side.ey[31]}}, in_side.ey};
      vx_in[0] = sat32(sx + {px[34], px});
      vy_in[0] = sat32(sy + {py[34], py});
      vx_in[1] = sat32(sx - {px[34], px});
      vy_in[1] = sat32(sy - {py[34], py});
      vx_in[2] = sat32(ex + {px[34], px});
      vy_in[2] = sat32(ey + {py[34], py});
      vx_in[3] = sat32(ex - {px[34], px});
      vy_in[3] = sat32(ey - {py[34], py});
   end

   assign free = !busy_ff || (cnt_ff == LastCorner && !rsp_stall);
   assign load = in_valid && free;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 3'd0;
      end else if (busy_ff && !rsp_stall) begin
         if (cnt_ff == LastCorner) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
      if (load) begin
         vx_ff  <= vx_in;
         vy_ff  <= vy_in;
         col_ff <= in_side.col;
      end
   end

   assign rsp_valid     = busy_ff;
   assign rsp_vert_x    = vx_ff[corner_sel(cnt_ff)];
   assign rsp_vert_y    = vy_ff[corner_sel(cnt_ff)];
   assign rsp_vert_rgba = col_ff;
   assign rsp_corner    = cnt_ff;
   assign rsp_last      = (cnt_ff == LastCorner);
endmodule

[rtl/thick_line_quad_expander.sv]
// Top level of the thick line segment to two-triangle quad expander.
//
// req_ channel: one line segment per item (endpoints, half width, color).
// rsp_ channel: six vertices per segment, corners 0..5 in the order
//   A0 B0 A1 A1 B0 B1, last set on corner 5. A zero-length segment gives none.
// Path from accept to the first vertex: input register, six normalize
//   stages, a multiply stage, a 32-cell square root chain, a divider setup
//   stage and a 33-cell divider chain, then the sequencer.
// Throughput: set by the result channel, one vertex per cycle while
//   rsp_stall is low; segments enter back to back and queue in the pipeline.
// Stall: the whole pipeline holds when its tail item cannot move into the
//   sequencer; req_stall then rises. Dropped segments never stall it.
// Reset: clears all valid bits and the sequencer; no item is in flight.
`timescale 1ns / 1ps
module thick_line_quad_expander #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_start_x,
   input  logic [31:0] req_start_y,
   input  logic [31:0] req_end_x,
   input  logic [31:0] req_end_y,
   input  logic [31:0] req_half_width,
   input  logic [31:0] req_rgba,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_vert_x,
   output logic [31:0] rsp_vert_y,
   output logic [31:0] rsp_vert_rgba,
   output logic [2:0]  rsp_corner,
   output logic        rsp_last
);
   import tlqe_pkg::*;

   localparam logic [63:0] ShortLimit = 64'd1 << (2 * FRAC_BITS);

   logic adv;

   // input stage
   logic        in_v_ff;
   side_type    in_side_ff;
   logic [32:0] dx_ff;
   logic [32:0] dy_ff;
   logic [32:0] dx_in;
   logic [32:0] dy_in;

   assign dx_in = {req_end_x[31], req_end_x} - {req_start_x[31], req_start_x};
   assign dy_in = {req_end_y[31], req_end_y} - {req_start_y[31], req_start_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (adv) begin
         in_v_ff <= req_valid;
      end
      if (adv) begin
         in_side_ff.sx     <= req_start_x;
         in_side_ff.sy     <= req_start_y;
         in_side_ff.ex     <= req_end_x;
         in_side_ff.ey     <= req_end_y;
         in_side_ff.hw     <= req_half_width;
         in_side_ff.col    <= req_rgba;
         in_side_ff.dx_neg <= dx_in[32];
         in_side_ff.dy_pos <= !dy_in[32] && (dy_in != '0);
         in_side_ff.drop   <= 1'b0;
         dx_ff             <= dx_in;
         dy_ff             <= dy_in;
      end
   end

   // normalize: stage 0 magnitude, short check and right shift; 1..5 left shifts
   logic        nrm_v_ff    [0:5];
   side_type    nrm_side_ff [0:5];
   logic [30:0] nrm_a_ff    [0:5];
   logic [30:0] nrm_b_ff    [0:5];
   logic [32:0] mag_a;
   logic [32:0] mag_b;
   logic [32:0] mag_or;
   logic [4:0]  small_sum;
   logic        short_in;
   side_type    side0_in;

   always_comb begin
      mag_a  = dx_ff[32] ? 33'(-dx_ff) : dx_ff;
      mag_b  = dy_ff[32] ? 33'(-dy_ff) : dy_ff;
      mag_or = mag_a | mag_b;
      small_sum = ({3'b000, mag_a[1:0]} * {3'b000, mag_a[1:0]})
                + ({3'b000, mag_b[1:0]} * {3'b000, mag_b[1:0]});
      short_in = (mag_a[32:2] == '0) && (mag_b[32:2] == '0)
              && ((64'(small_sum) * ZeroLenScale) < ShortLimit);
      side0_in      = in_side_ff;
      side0_in.drop = short_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrm_v_ff[0] <= 1'b0;
      end else if (adv) begin
         nrm_v_ff[0] <= in_v_ff;
      end
      if (adv) begin
         nrm_side_ff[0] <= side0_in;
         nrm_a_ff[0] <= mag_or[32] ? mag_a[32:2] : (mag_or[31] ? mag_a[31:1] : mag_a[30:0]);
         nrm_b_ff[0] <= mag_or[32] ? mag_b[32:2] : (mag_or[31] ? mag_b[31:1] : mag_b[30:0]);
      end
   end

   for (genvar i = 1; i <= 5; i++) begin : g_nrm
      localparam int Sh = 16 >> (i - 1);
      logic [30:0] ab;
      logic        zero_top;
      assign ab       = nrm_a_ff[i-1] | nrm_b_ff[i-1];
      assign zero_top = (ab[30 -: Sh] == '0);
      always_ff @(posedge clock) begin
         if (reset) begin
            nrm_v_ff[i] <= 1'b0;
         end else if (adv) begin
            nrm_v_ff[i] <= nrm_v_ff[i-1];
         end
         if (adv) begin
            nrm_side_ff[i] <= nrm_side_ff[i-1];
            nrm_a_ff[i] <= zero_top ? (nrm_a_ff[i-1] << Sh) : nrm_a_ff[i-1];
            nrm_b_ff[i] <= zero_top ? (nrm_b_ff[i-1] << Sh) : nrm_b_ff[i-1];
         end
      end
   end

   // multiply stage
   logic        mul_v_ff;
   side_type    mul_side_ff;
   sq_type      mul_sq_ff;
   logic [61:0] aa;
   logic [61:0] bb;

   assign aa = nrm_a_ff[5] * nrm_a_ff[5];
   assign bb = nrm_b_ff[5] * nrm_b_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else if (adv) begin
         mul_v_ff <= nrm_v_ff[5];
      end
      if (adv) begin
         mul_side_ff    <= nrm_side_ff[5];
         mul_sq_ff.rem  <= '0;
         mul_sq_ff.root <= '0;
         mul_sq_ff.s    <= {2'b00, aa} + {2'b00, bb};
         mul_sq_ff.na   <= nrm_a_ff[5] * nrm_side_ff[5].hw;
         mul_sq_ff.nb   <= nrm_b_ff[5] * nrm_side_ff[5].hw;
      end
   end

   // square root chain
   logic     sq_v    [0:SqrtSteps];
   side_type sq_side [0:SqrtSteps];
   sq_type   sq_d    [0:SqrtSteps];

   assign sq_v[0]    = mul_v_ff;
   assign sq_side[0] = mul_side_ff;
   assign sq_d[0]    = mul_sq_ff;

   for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
      tlqe_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_v[i]),
         .in_side   (sq_side[i]),
         .in_sq     (sq_d[i]),
         .out_valid (sq_v[i+1]),
         .out_side  (sq_side[i+1]),
         .out_sq    (sq_d[i+1])
      );
   end

   // divider setup
   logic        dvs_v_ff;
   side_type    dvs_side_ff;
   dv_type      dvs_ff;
   logic [63:0] nx;
   logic [63:0] ny;

   assign nx = {1'b0, sq_d[SqrtSteps].na} + {33'd0, sq_d[SqrtSteps].root[31:1]};
   assign ny = {1'b0, sq_d[SqrtSteps].nb} + {33'd0, sq_d[SqrtSteps].root[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dvs_v_ff <= 1'b0;
      end else if (adv) begin
         dvs_v_ff <= sq_v[SqrtSteps];
      end
      if (adv) begin
         dvs_side_ff  <= sq_side[SqrtSteps];
         dvs_ff.len   <= sq_d[SqrtSteps].root;
         dvs_ff.rem_x <= {1'b0, nx[63:33]};
         dvs_ff.rem_y <= {1'b0, ny[63:33]};
         dvs_ff.n_x   <= nx[32:0];
         dvs_ff.n_y   <= ny[32:0];
         dvs_ff.q_x   <= '0;
         dvs_ff.q_y   <= '0;
      end
   end

   // divider chain
   logic     dv_v    [0:DivSteps];
   side_type dv_side [0:DivSteps];
   dv_type   dv_d    [0:DivSteps];

   assign dv_v[0]    = dvs_v_ff;
   assign dv_side[0] = dvs_side_ff;
   assign dv_d[0]    = dvs_ff;

   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      tlqe_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_v[i]),
         .in_side   (dv_side[i]),
         .in_dv     (dv_d[i]),
         .out_valid (dv_v[i+1]),
         .out_side  (dv_side[i+1]),
         .out_dv    (dv_d[i+1])
      );
   end

   // output sequencer
   logic tail_v;
   logic tail_drop;
   logic emit_free;

   assign tail_v    = dv_v[DivSteps];
   assign tail_drop = dv_side[DivSteps].drop;
   assign adv       = !tail_v || tail_drop || emit_free;
   assign req_stall = !adv;

   tlqe_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (tail_v && !tail_drop),
      .in_side       (dv_side[DivSteps]),
      .in_qx         (dv_d[DivSteps].q_x),
      .in_qy         (dv_d[DivSteps].q_y),
      .free          (emit_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_vert_x    (rsp_vert_x),
      .rsp_vert_y    (rsp_vert_y),
      .rsp_vert_rgba (rsp_vert_rgba),
      .rsp_corner    (rsp_corner),
      .rsp_last      (rsp_last)
   );

   a_corner_steps : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_corner == $past(rsp_corner) + 3'd1)
      else $error("corner sequence broken");

   a_corner_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_corner <= LastCorner)
      else $error("corner out of range");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> tail_v && !tail_drop && rsp_valid)
      else $error("input stalled without a waiting item");

endmodule
